FILE: rtl/drl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drl_pkg: shared types and constants for the run list decoder
// Parser phases, error codes and the records passed between pipeline stages.
// ----------------------------------------------------------------------------
package drl_pkg;

	localparam int BYTE_W   = 8;
	localparam int NIB_W    = 4;
	localparam int RPC_W    = 7;
	localparam int OUT_W    = 48;
	localparam int VAL_W    = 64;
	localparam int PROD_W   = VAL_W + RPC_W;

	// header nibble mask
	localparam logic [NIB_W-1:0] NIB_MASK = 4'hF;

	// error codes on the result tuser
	localparam logic [1:0] BAD_OK     = 2'd0;
	localparam logic [1:0] BAD_COUNT  = 2'd1;
	localparam logic [1:0] BAD_LENGTH = 2'd2;
	localparam logic [1:0] BAD_TRUNC  = 2'd3;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_LENGTH = 2'd1,
		PH_OFFSET = 2'd2,
		PH_HALTED = 2'd3
	} phase_t;

	// parser event, one per accepted byte
	typedef struct packed {
		logic             emit;    // byte produces a result
		logic             is_run;  // result is a completed run
		logic             first;   // byte restarts the list
		logic             done;    // list ends with this result
		logic [1:0]       bad;     // error code for non-run results
		logic [NIB_W-1:0] len_n;   // length byte count
		logic [NIB_W-1:0] off_n;   // offset byte count
	} ev_t;

	// run arithmetic, before record saturation
	typedef struct packed {
		logic [OUT_W-1:0]  cluster;
		logic [OUT_W-1:0]  clen;
		logic [PROD_W-1:0] prod;
		logic              sparse;
		logic              done;
		logic [1:0]        bad;
	} calc_t;

endpackage
`default_nettype wire

FILE: rtl/drl_parse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drl_parse: run list byte parser
// Walks header, length and offset bytes, gathers the little-endian fields
// and registers one event per byte for the run arithmetic stage.
// ----------------------------------------------------------------------------
module drl_parse #(
	parameter int MAX_FIELD_BYTES = 8,
	localparam int AW = 8 * MAX_FIELD_BYTES
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [7:0]          s_tdata,    // data_byte
	input  wire logic                s_tuser,    // first_byte
	input  wire logic                s_tlast,    // final_byte
	output logic                     ev_valid,
	input  wire logic                ev_ready,
	output drl_pkg::ev_t             ev,
	output logic [AW-1:0]            ev_len_acc,
	output logic [AW-1:0]            ev_off_acc
);
	import drl_pkg::*;

	phase_t           phase_q, phase_d;
	logic [NIB_W-1:0] len_n_q, len_n_d;
	logic [NIB_W-1:0] off_n_q, off_n_d;
	logic [NIB_W-1:0] pos_q, pos_d;
	logic [NIB_W-1:0] pos_inc;
	logic [AW-1:0]    len_acc_q, len_acc_d;
	logic [AW-1:0]    off_acc_q, off_acc_d;
	logic [AW-1:0]    len_merge, off_merge;
	phase_t           ph;
	logic             trunc_chk;
	logic             accept;
	ev_t              ev_d;

	assign s_tready = !ev_valid || ev_ready;
	assign accept   = s_tvalid && s_tready;
	assign pos_inc  = pos_q + 4'd1;

	// drop the incoming byte into its lane of each accumulator
	always_comb begin
		len_merge = len_acc_q;
		off_merge = off_acc_q;
		for (int i = 0; i < MAX_FIELD_BYTES; i++) begin
			if (pos_q == NIB_W'(i)) begin
				len_merge[8*i +: 8] = s_tdata;
				off_merge[8*i +: 8] = s_tdata;
			end
		end
	end

	// next state and event
	always_comb begin
		phase_d   = phase_q;
		len_n_d   = len_n_q;
		off_n_d   = off_n_q;
		pos_d     = pos_q;
		len_acc_d = len_acc_q;
		off_acc_d = off_acc_q;
		trunc_chk = 1'b0;
		ev_d      = '0;
		ev_d.first = s_tuser;
		ph = s_tuser ? PH_HEADER : phase_q;

		unique case (ph)
			PH_HEADER: begin
				if (s_tdata == '0) begin
					phase_d   = PH_HALTED;
					ev_d.emit = 1'b1;
					ev_d.done = 1'b1;
					ev_d.bad  = BAD_OK;
				end else begin
					len_n_d = s_tdata[3:0] & NIB_MASK;
					off_n_d = s_tdata[7:4] & NIB_MASK;
					if (len_n_d > NIB_W'(MAX_FIELD_BYTES) ||
					    off_n_d > NIB_W'(MAX_FIELD_BYTES)) begin
						phase_d   = PH_HALTED;
						ev_d.emit = 1'b1;
						ev_d.done = s_tlast;
						ev_d.bad  = BAD_COUNT;
					end else begin
						len_acc_d = '0;
						off_acc_d = '0;
						pos_d     = '0;
						phase_d   = (len_n_d != '0) ? PH_LENGTH : PH_OFFSET;
						trunc_chk = 1'b1;
					end
				end
			end
			PH_LENGTH: begin
				len_acc_d = len_merge;
				if (pos_inc >= len_n_q) begin
					pos_d = '0;
					if (off_n_q == '0) begin
						ev_d.emit   = 1'b1;
						ev_d.is_run = 1'b1;
						ev_d.done   = s_tlast;
						phase_d     = s_tlast ? PH_HALTED : PH_HEADER;
					end else begin
						phase_d   = PH_OFFSET;
						trunc_chk = 1'b1;
					end
				end else begin
					pos_d     = pos_inc;
					trunc_chk = 1'b1;
				end
			end
			PH_OFFSET: begin
				off_acc_d = off_merge;
				if (pos_inc >= off_n_q) begin
					pos_d       = '0;
					ev_d.emit   = 1'b1;
					ev_d.is_run = 1'b1;
					ev_d.done   = s_tlast;
					phase_d     = s_tlast ? PH_HALTED : PH_HEADER;
				end else begin
					pos_d     = pos_inc;
					trunc_chk = 1'b1;
				end
			end
			PH_HALTED: begin
				// ignore bytes until the next list start
			end
			default: begin
				phase_d = PH_HALTED;
			end
		endcase

		// attribute ends in the middle of a run
		if (trunc_chk && s_tlast) begin
			phase_d   = PH_HALTED;
			pos_d     = '0;
			ev_d.emit = 1'b1;
			ev_d.done = 1'b1;
			ev_d.bad  = BAD_TRUNC;
		end

		ev_d.len_n = len_n_d;
		ev_d.off_n = off_n_d;
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			len_n_q <= '0;
			off_n_q <= '0;
			pos_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			len_n_q <= len_n_d;
			off_n_q <= off_n_d;
			pos_q   <= pos_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			len_acc_q <= len_acc_d;
			off_acc_q <= off_acc_d;
		end
	end

	// event register, stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid <= 1'b0;
		end else if (s_tready) begin
			ev_valid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ev         <= ev_d;
			ev_len_acc <= len_acc_d;
			ev_off_acc <= off_acc_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/drl_run.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drl_run: run arithmetic and result register
// Sign-extends the gathered fields, moves the running cluster, forms the
// record count and saturates it into the output register.
// ----------------------------------------------------------------------------
module drl_run #(
	parameter int MAX_FIELD_BYTES = 8,
	parameter int CLUSTER_WIDTH   = 48,
	localparam int AW = 8 * MAX_FIELD_BYTES
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                ev_valid,
	output logic                     ev_ready,
	input  wire drl_pkg::ev_t        ev,
	input  wire logic [AW-1:0]       ev_len_acc,
	input  wire logic [AW-1:0]       ev_off_acc,
	input  wire logic [6:0]          rpc,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [143:0]             m_tdata,    // run_cluster, run_clusters, record_total
	output logic [2:0]               m_tuser,    // sparse_run, bad_run[1:0]
	output logic                     m_tlast     // list_done
);
	import drl_pkg::*;

	localparam logic [VAL_W-1:0] CL_MASK =
		VAL_W'((65'd1 << CLUSTER_WIDTH) - 65'd1);

	// sign-extend the low n bytes of v
	function automatic logic [AW-1:0] sext_bytes(input logic [AW-1:0] v,
	                                             input logic [NIB_W-1:0] n);
		logic [AW-1:0] keep;
		logic [AW-1:0] top;
		keep = ~({AW{1'b1}} << {n, 3'b000});
		top  = keep & ~(keep >> 1);
		return (v & keep) | (((v & top) != '0) ? ~keep : '0);
	endfunction

	logic [VAL_W-1:0]         len_x, off_x;
	logic                     len_ok;
	logic [CLUSTER_WIDTH-1:0] rc_q, rc_base, rc_sum;
	logic                     rc_add;
	calc_t                    calc_d, calc_s2;
	logic                     s2_valid_s2;
	logic                     s2_ready, out_en;
	logic [VAL_W-1:0]         rec;

	// stage 2: field extension, cluster add, record product
	always_comb begin
		len_x   = VAL_W'($signed(sext_bytes(ev_len_acc, ev.len_n)));
		off_x   = VAL_W'($signed(sext_bytes(ev_off_acc, ev.off_n)));
		len_ok  = (ev.len_n != '0) && (len_x != '0) && !len_x[VAL_W-1];
		rc_base = ev.first ? '0 : rc_q;
		rc_sum  = rc_base + off_x[CLUSTER_WIDTH-1:0];
		rc_add  = ev.is_run && len_ok && (ev.off_n != '0);

		calc_d      = '0;
		calc_d.done = ev.done;
		calc_d.bad  = ev.bad;
		if (ev.is_run) begin
			if (!len_ok) begin
				calc_d.bad = BAD_LENGTH;
			end else begin
				calc_d.bad     = BAD_OK;
				calc_d.cluster = (ev.off_n != '0) ? OUT_W'(rc_sum) : '0;
				calc_d.clen    = OUT_W'((len_x > CL_MASK) ? CL_MASK : len_x);
				calc_d.prod    = PROD_W'(len_x) * PROD_W'(rpc);
				calc_d.sparse  = (ev.off_n == '0);
			end
		end
	end

	assign out_en   = !m_tvalid || m_tready;
	assign s2_ready = !s2_valid_s2 || out_en;
	assign ev_ready = s2_ready;

	// running cluster, cleared by a list start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q <= '0;
		end else if (ev_valid && s2_ready) begin
			if (rc_add) begin
				rc_q <= rc_sum;
			end else if (ev.first) begin
				rc_q <= '0;
			end
		end
	end

	// stage 2 register, only bytes that give a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			s2_valid_s2 <= ev_valid && ev.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready) begin
			calc_s2 <= calc_d;
		end
	end

	// record count saturation
	assign rec = (calc_s2.prod > PROD_W'(CL_MASK)) ? CL_MASK : calc_s2.prod[VAL_W-1:0];

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_en) begin
			m_tvalid <= s2_valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && s2_valid_s2) begin
			m_tdata <= {OUT_W'(rec), calc_s2.clen, calc_s2.cluster};
			m_tuser <= {calc_s2.bad, calc_s2.sparse};
			m_tlast <= calc_s2.done;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/disk_runlist_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// disk_runlist_decoder: file-system run list decoder
// Turns a byte stream of run headers, lengths and offsets into one result per
// run, error or list end: start cluster, length, record count, error status.
// ----------------------------------------------------------------------------
// One run list byte is taken per clock cycle, back to back, with no stall of
// its own; the input waits only when the result side backs up through the
// three register stages (byte parser, run arithmetic, result register).
// Mark the first byte of each list in s_tuser and the last byte of the
// holding attribute in s_tlast. records_per_cluster resets to 4 and is
// written through cfg_wen/cfg_wdata; the user must write it only while no
// byte is in flight, as the block itself does not enforce this. There is
// no clearing pass after reset.
module disk_runlist_decoder #(
	parameter int MAX_FIELD_BYTES = 8,
	parameter int CLUSTER_WIDTH   = 48
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_wen,
	input  wire logic [6:0]   cfg_wdata,  // records_per_cluster
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,    // data_byte
	input  wire logic         s_tuser,    // first_byte
	input  wire logic         s_tlast,    // final_byte
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [143:0]      m_tdata,    // run_cluster, run_clusters, record_total
	output logic [2:0]        m_tuser,    // sparse_run, bad_run[1:0]
	output logic              m_tlast     // list_done
);
	import drl_pkg::*;

	localparam int AW = 8 * MAX_FIELD_BYTES;

	logic [RPC_W-1:0] rpc_q;
	logic             ev_valid, ev_ready;
	ev_t              ev;
	logic [AW-1:0]    ev_len_acc, ev_off_acc;

	// records per cluster register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpc_q <= 7'd4;
		end else if (cfg_wen) begin
			rpc_q <= cfg_wdata;
		end
	end

	drl_parse #(
		.MAX_FIELD_BYTES (MAX_FIELD_BYTES)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.ev_valid   (ev_valid),
		.ev_ready   (ev_ready),
		.ev         (ev),
		.ev_len_acc (ev_len_acc),
		.ev_off_acc (ev_off_acc)
	);

	drl_run #(
		.MAX_FIELD_BYTES (MAX_FIELD_BYTES),
		.CLUSTER_WIDTH   (CLUSTER_WIDTH)
	) u_run (
		.clk        (clk),
		.arst_n     (arst_n),
		.ev_valid   (ev_valid),
		.ev_ready   (ev_ready),
		.ev         (ev),
		.ev_len_acc (ev_len_acc),
		.ev_off_acc (ev_off_acc),
		.rpc        (rpc_q),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule
`default_nettype wire

FILE: tb/disk_runlist_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// disk_runlist_decoder_tb: self-checking bench for the run list decoder
// Feeds directed and random run lists byte by byte over the input stream,
// predicts every run, error and end-of-list result in the bench, and checks
// the output stream field by field under several idle and stall mixes and
// records-per-cluster settings.
// ----------------------------------------------------------------------------
module disk_runlist_decoder_tb;
	import drl_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;     // three register stages plus margin
	localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
	localparam int MAX_BYTES    = 8;
	localparam int PHASE_BYTES  = 150;
	localparam logic [OUT_W-1:0] CL_MAX = '1;

	// one output transaction, unpacked from tdata/tuser/tlast
	typedef struct packed {
		logic [OUT_W-1:0] cluster;
		logic [OUT_W-1:0] clusters;
		logic [OUT_W-1:0] records;
		logic             sparse;
		logic             done;
		logic [1:0]       bad;
	} run_result_t;

	// one input byte, with an optional hand-written expectation
	typedef struct packed {
		logic [BYTE_W-1:0] val;
		logic              is_first;
		logic              is_final;
		logic              has_want;
		run_result_t       want;
	} rl_byte_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_wen;
	logic [6:0]   cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;    // data_byte
	logic         s_tuser;    // first_byte
	logic         s_tlast;    // final_byte
	logic         m_tvalid;
	logic         m_tready;
	logic [143:0] m_tdata;    // run_cluster, run_clusters, record_total
	logic [2:0]   m_tuser;    // sparse_run, bad_run[1:0]
	logic         m_tlast;    // list_done

	disk_runlist_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// bench-side decoder state
	phase_t             ph       = PH_HEADER;
	logic [NIB_W-1:0]   len_n    = '0;
	logic [NIB_W-1:0]   off_n    = '0;
	logic [NIB_W-1:0]   pos      = '0;
	logic [VAL_W-1:0]   len_acc  = '0;
	logic [VAL_W-1:0]   off_acc  = '0;
	logic [OUT_W-1:0]   run_base = '0;
	logic [RPC_W-1:0]   rpc      = 7'd4;

	run_result_t results_due[$];

	// handshake and idling control
	bit          in_xfer;
	logic        cur_has_want;
	run_result_t cur_want;
	int          src_idle_pct;
	int          sink_stall_pct;
	int          hold_reqs;
	int          hold_seen;
	int          hold_left;

	// bookkeeping
	int err_count;
	int cycle_count;
	int bytes_in;
	int results_seen;
	int runs_seen;
	int sparse_seen;
	int bad_seen;
	int ends_seen;
	int cfg_writes;

	rl_byte_t dir_tab [25];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------

	// sign-extend the low n bytes of v
	function automatic logic [VAL_W-1:0] sign_ext(input logic [VAL_W-1:0] v,
			input logic [NIB_W-1:0] n);
		logic [VAL_W-1:0] keep;
		if (n >= MAX_BYTES) return v;
		keep = (64'd1 << (n * 8)) - 64'd1;
		v = v & keep;
		if (v[n * 8 - 1]) v = v | ~keep;
		return v;
	endfunction

	// close a run whose last length or offset byte just arrived
	function automatic run_result_t close_run(input logic fin);
		logic [VAL_W-1:0] len;
		logic [VAL_W-1:0] lim;
		logic [VAL_W-1:0] delta;
		run_result_t      r;
		r = '0;
		r.done = fin;
		ph = fin ? PH_HALTED : PH_HEADER;
		pos = '0;
		if (len_n == 0) begin
			r.bad = BAD_LENGTH;
			return r;
		end
		len = sign_ext(len_acc, len_n);
		if (len == 0 || len[VAL_W-1]) begin
			r.bad = BAD_LENGTH;
			return r;
		end
		lim = {{(VAL_W-OUT_W){1'b0}}, CL_MAX};
		r.clusters = (len > lim) ? CL_MAX : len[OUT_W-1:0];
		if (rpc != 0 && len > lim / {{(VAL_W-RPC_W){1'b0}}, rpc})
			r.records = CL_MAX;
		else
			r.records = len[OUT_W-1:0] * rpc;
		// sparse runs leave the running cluster alone
		if (off_n != 0) begin
			delta = sign_ext(off_acc, off_n);
			run_base = run_base + delta[OUT_W-1:0];
			r.cluster = run_base;
		end
		r.sparse = (off_n == 0);
		r.bad = BAD_OK;
		return r;
	endfunction

	// advance the decoder by one byte; returns 1 when a result is due
	function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic is_first,
			input logic fin, output run_result_t r);
		r = '0;
		if (is_first) begin
			run_base = '0;
			ph = PH_HEADER;
		end
		case (ph)
			PH_HEADER: begin
				if (b == 0) begin
					ph = PH_HALTED;
					r.done = 1'b1;
					return 1'b1;
				end
				len_n = b[3:0] & NIB_MASK;
				off_n = b[7:4] & NIB_MASK;
				if (len_n > MAX_BYTES || off_n > MAX_BYTES) begin
					ph = PH_HALTED;
					r.done = fin;
					r.bad = BAD_COUNT;
					return 1'b1;
				end
				len_acc = '0;
				off_acc = '0;
				pos = '0;
				ph = (len_n != 0) ? PH_LENGTH : PH_OFFSET;
			end
			PH_LENGTH: begin
				len_acc = len_acc | ({56'b0, b} << (pos[2:0] * 8));
				pos++;
				if (pos >= len_n) begin
					pos = '0;
					if (off_n == 0) begin
						r = close_run(fin);
						return 1'b1;
					end
					ph = PH_OFFSET;
				end
			end
			PH_OFFSET: begin
				off_acc = off_acc | ({56'b0, b} << (pos[2:0] * 8));
				pos++;
				if (pos >= off_n) begin
					r = close_run(fin);
					return 1'b1;
				end
			end
			default: return 1'b0;
		endcase
		// attribute ended in the middle of a run
		if (fin) begin
			ph = PH_HALTED;
			pos = '0;
			r.done = 1'b1;
			r.bad = BAD_TRUNC;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		if (err_count < 40) $display("[%0t] mismatch: %s", $time, msg);
		err_count++;
	endtask

	// sample both sides at the rising edge
	always @(posedge clk) begin
		run_result_t nxt;
		run_result_t got;
		run_result_t want;
		bit          made;
		in_xfer = arst_n && s_tvalid && s_tready;
		if (cfg_wen) rpc = cfg_wdata;
		if (in_xfer) begin
			made = decode_byte(s_tdata, s_tuser, s_tlast, nxt);
			if (cur_has_want) results_due.insert(results_due.size(), cur_want);
			else if (made) results_due.insert(results_due.size(), nxt);
			bytes_in++;
		end
		if (arst_n && m_tvalid && m_tready) begin
			got.cluster  = m_tdata[47:0];
			got.clusters = m_tdata[95:48];
			got.records  = m_tdata[143:96];
			got.sparse   = m_tuser[0];
			got.bad      = m_tuser[2:1];
			got.done     = m_tlast;
			if (results_due.size() == 0) begin
				report_mismatch($sformatf("result %0d with nothing due: %h", results_seen, got));
			end else begin
				want = results_due.pop_front();
				if (got.cluster !== want.cluster)
					report_mismatch($sformatf("result %0d run_cluster %h, want %h",
						results_seen, got.cluster, want.cluster));
				if (got.clusters !== want.clusters)
					report_mismatch($sformatf("result %0d run_clusters %h, want %h",
						results_seen, got.clusters, want.clusters));
				if (got.records !== want.records)
					report_mismatch($sformatf("result %0d record_total %h, want %h",
						results_seen, got.records, want.records));
				if (got.sparse !== want.sparse)
					report_mismatch($sformatf("result %0d sparse_run %b, want %b",
						results_seen, got.sparse, want.sparse));
				if (got.done !== want.done)
					report_mismatch($sformatf("result %0d list_done %b, want %b",
						results_seen, got.done, want.done));
				if (got.bad !== want.bad)
					report_mismatch($sformatf("result %0d bad_run %0d, want %0d",
						results_seen, got.bad, want.bad));
				if (want.clusters != 0) runs_seen++;
				if (want.clusters != 0 && want.sparse) sparse_seen++;
				if (want.bad != BAD_OK) bad_seen++;
				if (want.done) ends_seen++;
			end
			results_seen++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due",
				cycle_count, results_due.size());
			$display("disk_runlist_decoder_tb: errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// receiver: random stalls plus an occasional long hold-off
	// ------------------------------------------------------------------
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// sender
	// ------------------------------------------------------------------

	function automatic run_result_t res(input logic [OUT_W-1:0] cl, input logic [OUT_W-1:0] len,
			input logic [OUT_W-1:0] rec, input logic sp, input logic dn, input logic [1:0] bad);
		run_result_t r;
		r.cluster = cl;
		r.clusters = len;
		r.records = rec;
		r.sparse = sp;
		r.done = dn;
		r.bad = bad;
		return r;
	endfunction

	function automatic rl_byte_t in_byte(input logic [BYTE_W-1:0] v, input logic f,
			input logic l);
		rl_byte_t it;
		it.val = v;
		it.is_first = f;
		it.is_final = l;
		it.has_want = 1'b0;
		it.want = '0;
		return it;
	endfunction

	function automatic rl_byte_t in_byte_res(input logic [BYTE_W-1:0] v, input logic f,
			input logic l, input run_result_t w);
		rl_byte_t it;
		it = in_byte(v, f, l);
		it.has_want = 1'b1;
		it.want = w;
		return it;
	endfunction

	// offer one byte, called and returning at a falling edge
	task automatic drive_byte(input rl_byte_t it);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid     <= 1'b1;
		s_tdata      <= it.val;
		s_tuser      <= it.is_first;
		s_tlast      <= it.is_final;
		cur_has_want <= it.has_want;
		cur_want     <= it.want;
		do @(negedge clk); while (!in_xfer);
	endtask

	// stop sending and let everything in flight come out
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (results_due.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_rpc(input logic [RPC_W-1:0] v);
		wait_idle();
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_wen   <= 1'b0;
		cfg_writes++;
	endtask

	// one random run list: mostly well-formed runs, with bad lengths, cut
	// lists, bad byte counts and trailing junk mixed in
	task automatic send_list(inout int counted);
		logic [BYTE_W-1:0] seq [0:16];
		logic [3:0]        lo;
		logic [3:0]        hi;
		logic              any;
		int                nrun;
		int                kind;
		int                ln;
		int                on;
		int                n;
		int                cut;
		int                ending;
		nrun = $urandom_range(1, 5);
		ending = $urandom_range(99);   // <60 zero header, then final, truncated, cut, bad count
		for (int r = 0; r < nrun; r++) begin
			kind = $urandom_range(99);
			ln = ($urandom_range(9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
			on = ($urandom_range(5) == 0) ? 0 :
				(($urandom_range(9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3));
			if (kind < 5) begin
				ln = 0;
				if (on == 0) on = 1;
			end else if (kind < 9) begin
				ln = 8;
			end
			n = 1 + ln + on;
			seq[0] = {on[3:0], ln[3:0]};
			for (int i = 1; i < n; i++) seq[i] = 8'($urandom_range(255));
			if (ln != 0) begin
				if (kind < 9) begin
					// largest positive length, saturates length and record count if rpc != 0
					for (int i = 1; i <= ln; i++) seq[i] = 8'hFF;
					seq[ln] = 8'h7F;
				end else if (kind < 14) begin
					seq[ln] = seq[ln] | 8'h80;
				end else if (kind < 17) begin
					for (int i = 1; i <= ln; i++) seq[i] = 8'h00;
				end else begin
					seq[ln] = seq[ln] & 8'h7F;
					any = 1'b0;
					for (int i = 1; i <= ln; i++) any = any | (seq[i] != 0);
					if (!any) seq[1] = 8'h01;
				end
			end
			cut = n - 1;
			if (r == nrun - 1 && ending >= 70 && ending < 90) cut = $urandom_range(0, n - 2);
			for (int i = 0; i <= cut; i++) begin
				drive_byte(in_byte(seq[i], r == 0 && i == 0,
					r == nrun - 1 && i == cut && ending >= 60 && ending < 80));
				counted++;
			end
		end
		if (ending < 60) begin
			drive_byte(in_byte(8'h00, 1'b0, $urandom_range(3) == 0));
			counted++;
		end else if (ending >= 90) begin
			lo = 4'($urandom_range(9, 15));
			hi = 4'($urandom_range(15));
			drive_byte(in_byte($urandom_range(1) ? {hi, lo} : {lo, hi}, 1'b0,
				$urandom_range(3) == 0));
			counted++;
		end
		// bytes after the end of a list are ignored
		if (ending < 80 || ending >= 90) begin
			repeat ($urandom_range(0, 2)) begin
				drive_byte(in_byte(8'($urandom_range(255)), 1'b0, $urandom_range(1)));
				counted++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		logic [RPC_W-1:0] rpc_plan [4];
		int               src_plan [4];
		int               sink_plan [4];
		int               phase_bytes;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		s_tlast = 1'b0;
		cur_has_want = 1'b0;
		cur_want = '0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed lists at the reset value of four records per cluster
		dir_tab = '{
			in_byte(8'h11, 1'b1, 1'b0),
			in_byte(8'h05, 1'b0, 1'b0),
			in_byte_res(8'h10, 1'b0, 1'b0, res(48'd16, 48'd5, 48'd20, 1'b0, 1'b0, BAD_OK)),
			in_byte(8'h01, 1'b0, 1'b0),
			in_byte_res(8'h7F, 1'b0, 1'b0, res(48'd0, 48'd127, 48'd508, 1'b1, 1'b0, BAD_OK)),
			// eight length bytes: saturated length and record count
			in_byte(8'h08, 1'b0, 1'b0),
			in_byte(8'hFF, 1'b0, 1'b0),
			in_byte(8'hFF, 1'b0, 1'b0),
			in_byte(8'hFF, 1'b0, 1'b0),
			in_byte(8'hFF, 1'b0, 1'b0),
			in_byte(8'hFF, 1'b0, 1'b0),
			in_byte(8'hFF, 1'b0, 1'b0),
			in_byte(8'hFF, 1'b0, 1'b0),
			in_byte_res(8'h7F, 1'b0, 1'b0, res(48'd0, CL_MAX, CL_MAX, 1'b1, 1'b0, BAD_OK)),
			// no length bytes, then a negative length
			in_byte(8'h10, 1'b0, 1'b0),
			in_byte_res(8'h05, 1'b0, 1'b0, res(48'd0, 48'd0, 48'd0, 1'b0, 1'b0, BAD_LENGTH)),
			in_byte(8'h11, 1'b0, 1'b0),
			in_byte(8'h80, 1'b0, 1'b0),
			in_byte_res(8'h03, 1'b0, 1'b0, res(48'd0, 48'd0, 48'd0, 1'b0, 1'b0, BAD_LENGTH)),
			// zero header ends the list, next byte is ignored
			in_byte_res(8'h00, 1'b0, 1'b0, res(48'd0, 48'd0, 48'd0, 1'b0, 1'b1, BAD_OK)),
			in_byte(8'h42, 1'b0, 1'b0),
			// offset count too large
			in_byte_res(8'h91, 1'b1, 1'b0, res(48'd0, 48'd0, 48'd0, 1'b0, 1'b0, BAD_COUNT)),
			// attribute ends in the middle of a run
			in_byte(8'h21, 1'b1, 1'b0),
			in_byte_res(8'h01, 1'b0, 1'b1, res(48'd0, 48'd0, 48'd0, 1'b0, 1'b1, BAD_TRUNC)),
			// bad count on the final byte wins over truncation
			in_byte_res(8'hF0, 1'b1, 1'b1, res(48'd0, 48'd0, 48'd0, 1'b0, 1'b1, BAD_COUNT))
		};
		for (int i = 0; i < 25; i++) drive_byte(dir_tab[i]);
		wait_idle();

		// random lists under each idle mix and register setting
		rpc_plan  = '{7'd64, 7'd0, 7'd63, 7'd1};
		src_plan  = '{0, 47, 0, 8};
		sink_plan = '{0, 0, 47, 8};
		for (int p = 0; p < 4; p++) begin
			write_rpc(rpc_plan[p]);
			src_idle_pct = src_plan[p];
			sink_stall_pct = sink_plan[p];
			// receiver holds off while the sender keeps offering bytes
			if (p == 2) hold_reqs++;
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) send_list(phase_bytes);
		end
		wait_idle();

		$display("summary: %0d bytes taken, %0d results checked: %0d runs (%0d sparse), %0d bad",
			bytes_in, results_seen, runs_seen, sparse_seen, bad_seen);
		$display("summary: %0d list ends, %0d register writes, %0d cycles",
			ends_seen, cfg_writes, cycle_count);
		if (err_count == 0)
			$display("disk_runlist_decoder_tb: clean");
		else
			$display("disk_runlist_decoder_tb: errors");
		$finish;
	end

endmodule
